[rtl/core/bresl_pkg.sv]
`timescale 1ns / 1ps

package bresl_pkg;

  // Fixed field widths.
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 9;
  localparam int COLOUR_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Command codes carried in the cmd field.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BASE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

  // Reset values of the screen size registers.
  localparam logic [SIZE_W-1:0] RESET_SCREEN_WIDTH  = 9'd320;
  localparam logic [SIZE_W-1:0] RESET_SCREEN_HEIGHT = 9'd240;

  // Control flags of the line walk.
  typedef struct packed {
    logic active;
    logic steep;
    logic minor_dir_down;
  } bresl_flags_t;

endpackage

[rtl/core/bresenham_line_rasterizer.sv]
`timescale 1ns / 1ps

// Bresenham line rasterizer. A load word (cmd 0) latches two signed endpoints
// and a colour and yields no result word; each step word (cmd 1) yields exactly
// one result word carrying the next pixel of the line, its clip flag against
// screen_width and screen_height, its byte address
// frame_base + (y << ROW_SHIFT) + (x << 1) and a last flag on the final pixel.
// A step with no line loaded, or after the last pixel, yields a word with every
// field zero. One input word is taken every clock cycle: the load set-up sits in a
// single combinational pass from the input word to the line state registers, the
// per-pixel error update in one from those registers to the output register, and
// the output register lets a new word in while the previous result is still being
// taken (in_ready is low only when a result is held and out_ready is low).
// Configuration writes take effect at the next edge and must only be made
// while no line word is outstanding.

module bresenham_line_rasterizer import bresl_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int ROW_SHIFT  = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [COLOUR_W-1:0]          colour,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pixel_valid,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         visible,
  output logic [ADDR_W-1:0]            pixel_address,
  output logic [COLOUR_W-1:0]          pixel_colour,
  output logic                         last
);

  // Configuration registers.
  logic [ADDR_W-1:0] frame_base;
  logic [SIZE_W-1:0] screen_width;
  logic [SIZE_W-1:0] screen_height;

  // Line walk state. Only the flags need a reset: the rest is always written
  // by a load before a step reads it.
  bresl_flags_t                 flags;
  logic signed [COORD_BITS-1:0] major_pos;
  logic signed [COORD_BITS-1:0] major_end;
  logic signed [COORD_BITS-1:0] minor_pos;
  logic        [COORD_BITS-1:0] delta_major;
  logic        [COORD_BITS-1:0] delta_minor;
  logic signed [COORD_BITS+1:0] error_term;
  logic        [COLOUR_W-1:0]   line_colour;

  // Outputs of the load set-up.
  bresl_flags_t                 setup_flags;
  logic signed [COORD_BITS-1:0] setup_major_pos;
  logic signed [COORD_BITS-1:0] setup_major_end;
  logic signed [COORD_BITS-1:0] setup_minor_pos;
  logic        [COORD_BITS-1:0] setup_delta_major;
  logic        [COORD_BITS-1:0] setup_delta_minor;
  logic signed [COORD_BITS+1:0] setup_error;

  // Outputs of the pixel step.
  logic signed [COORD_BITS-1:0] step_x;
  logic signed [COORD_BITS-1:0] step_y;
  logic                         step_visible;
  logic [ADDR_W-1:0]            step_address;
  logic                         step_last;
  logic signed [COORD_BITS-1:0] major_next;
  logic signed [COORD_BITS-1:0] minor_next;
  logic signed [COORD_BITS+1:0] error_next;

  logic in_fire;
  logic load_fire;
  logic step_fire;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (cmd == CMD_LOAD);
  assign step_fire = in_fire && (cmd == CMD_STEP);

  bresl_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .flags       (setup_flags),
    .major_pos   (setup_major_pos),
    .major_end   (setup_major_end),
    .minor_pos   (setup_minor_pos),
    .delta_major (setup_delta_major),
    .delta_minor (setup_delta_minor),
    .error_init  (setup_error)
  );

  bresl_step #(
    .COORD_BITS (COORD_BITS),
    .ROW_SHIFT  (ROW_SHIFT)
  ) u_step (
    .flags         (flags),
    .major_pos     (major_pos),
    .major_end     (major_end),
    .minor_pos     (minor_pos),
    .delta_major   (delta_major),
    .delta_minor   (delta_minor),
    .error_term    (error_term),
    .frame_base    (frame_base),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .x             (step_x),
    .y             (step_y),
    .visible       (step_visible),
    .address       (step_address),
    .is_last       (step_last),
    .major_next    (major_next),
    .minor_next    (minor_next),
    .error_next    (error_next)
  );

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base    <= '0;
      screen_width  <= RESET_SCREEN_WIDTH;
      screen_height <= RESET_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_BASE:    frame_base    <= cfg_data[ADDR_W-1:0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control flags and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_fire) begin
        flags <= setup_flags;
      end else if (step_fire && flags.active && step_last) begin
        flags.active <= 1'b0;
      end
      if (step_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk state: a load primes it, every step on an active line advances it.
  always_ff @(posedge clk) begin
    if (load_fire) begin
      major_pos   <= setup_major_pos;
      major_end   <= setup_major_end;
      minor_pos   <= setup_minor_pos;
      delta_major <= setup_delta_major;
      delta_minor <= setup_delta_minor;
      error_term  <= setup_error;
      line_colour <= colour;
    end else if (step_fire && flags.active) begin
      minor_pos  <= minor_next;
      error_term <= error_next;
      if (!step_last) begin
        major_pos <= major_next;
      end
    end
  end

  // Result register. A step with no active line gives an all-zero word.
  always_ff @(posedge clk) begin
    if (step_fire) begin
      pixel_valid   <= flags.active;
      pixel_x       <= flags.active ? step_x : '0;
      pixel_y       <= flags.active ? step_y : '0;
      visible       <= flags.active && step_visible;
      pixel_address <= flags.active ? step_address : '0;
      pixel_colour  <= flags.active ? line_colour : '0;
      last          <= flags.active && step_last;
    end
  end

  // A load always leaves a line ready to walk.
  a_load_activates: assert property (@(posedge clk) disable iff (rst)
    load_fire |=> flags.active)
    else $error("load did not activate the line");

  // The last pixel of a line ends the walk.
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (step_fire && flags.active && step_last) |=> !flags.active)
    else $error("line still active after its last pixel");

  // Every accepted step word produces a result word.
  a_step_gives_word: assert property (@(posedge clk) disable iff (rst)
    step_fire |=> out_valid)
    else $error("step word produced no result");

  // A load word produces no result of its own.
  a_load_no_word: assert property (@(posedge clk) disable iff (rst)
    (load_fire && out_ready) |=> !out_valid)
    else $error("load word produced a result");

  // Flags on a result word are only set for a real line pixel.
  a_flags_need_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (last || visible)) |-> pixel_valid)
    else $error("pixel flags set on an empty result");

endmodule

[rtl/core/bresl_setup.sv]
`timescale 1ns / 1ps

module bresl_setup import bresl_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output bresl_flags_t                 flags,
  output logic signed [COORD_BITS-1:0] major_pos,
  output logic signed [COORD_BITS-1:0] major_end,
  output logic signed [COORD_BITS-1:0] minor_pos,
  output logic        [COORD_BITS-1:0] delta_major,
  output logic        [COORD_BITS-1:0] delta_minor,
  output logic signed [COORD_BITS+1:0] error_init
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] ndx;
  logic signed [DW-1:0] ndy;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic steep;
  logic swap;
  logic signed [COORD_BITS-1:0] a0;
  logic signed [COORD_BITS-1:0] b0;
  logic signed [COORD_BITS-1:0] a1;
  logic signed [COORD_BITS-1:0] b1;
  logic signed [COORD_BITS-1:0] minor_end;

  always_comb begin
    dx  = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy  = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    ndx = -dx;
    ndy = -dy;
    adx = dx[DW-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady = dy[DW-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    steep = ady > adx;

    a0 = steep ? start_y : start_x;
    b0 = steep ? start_x : start_y;
    a1 = steep ? end_y   : end_x;
    b1 = steep ? end_x   : end_y;

    // Order the endpoints so the major coordinate runs upward.
    swap      = a0 > a1;
    major_pos = swap ? a1 : a0;
    major_end = swap ? a0 : a1;
    minor_pos = swap ? b1 : b0;
    minor_end = swap ? b0 : b1;

    delta_major = steep ? ady : adx;
    delta_minor = steep ? adx : ady;
    error_init  = -$signed({3'b000, delta_major[COORD_BITS-1:1]});

    flags.active         = 1'b1;
    flags.steep          = steep;
    flags.minor_dir_down = !(minor_pos < minor_end);
  end

endmodule

[rtl/core/bresl_step.sv]
`timescale 1ns / 1ps

module bresl_step import bresl_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int ROW_SHIFT  = 10
) (
  input  bresl_flags_t                 flags,
  input  logic signed [COORD_BITS-1:0] major_pos,
  input  logic signed [COORD_BITS-1:0] major_end,
  input  logic signed [COORD_BITS-1:0] minor_pos,
  input  logic        [COORD_BITS-1:0] delta_major,
  input  logic        [COORD_BITS-1:0] delta_minor,
  input  logic signed [COORD_BITS+1:0] error_term,
  input  logic        [ADDR_W-1:0]     frame_base,
  input  logic        [SIZE_W-1:0]     screen_width,
  input  logic        [SIZE_W-1:0]     screen_height,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y,
  output logic                         visible,
  output logic        [ADDR_W-1:0]     address,
  output logic                         is_last,
  output logic signed [COORD_BITS-1:0] major_next,
  output logic signed [COORD_BITS-1:0] minor_next,
  output logic signed [COORD_BITS+1:0] error_next
);

  localparam int CMP_W = (COORD_BITS > SIZE_W ? COORD_BITS : SIZE_W) + 1;

  logic signed [COORD_BITS+1:0] error_sum;
  logic                         move;
  logic [ADDR_W-1:0]            x_ext;
  logic [ADDR_W-1:0]            y_ext;
  logic [CMP_W-1:0]             x_cmp;
  logic [CMP_W-1:0]             y_cmp;
  logic [CMP_W-1:0]             w_cmp;
  logic [CMP_W-1:0]             h_cmp;

  always_comb begin
    x = flags.steep ? minor_pos : major_pos;
    y = flags.steep ? major_pos : minor_pos;
    is_last = major_pos >= major_end;

    x_ext   = {{(ADDR_W-COORD_BITS){x[COORD_BITS-1]}}, x};
    y_ext   = {{(ADDR_W-COORD_BITS){y[COORD_BITS-1]}}, y};
    address = frame_base + (y_ext << ROW_SHIFT) + (x_ext << 1);

    x_cmp = {{(CMP_W-COORD_BITS){1'b0}}, x};
    y_cmp = {{(CMP_W-COORD_BITS){1'b0}}, y};
    w_cmp = {{(CMP_W-SIZE_W){1'b0}}, screen_width};
    h_cmp = {{(CMP_W-SIZE_W){1'b0}}, screen_height};
    visible = !x[COORD_BITS-1] && !y[COORD_BITS-1] && (x_cmp < w_cmp) && (y_cmp < h_cmp);

    // The minor coordinate moves when the error reaches zero or more.
    error_sum  = error_term + $signed({2'b00, delta_minor});
    move       = !error_sum[COORD_BITS+1];
    minor_next = !move ? minor_pos :
                 (flags.minor_dir_down ? minor_pos - 1'b1 : minor_pos + 1'b1);
    error_next = move ? error_sum - $signed({2'b00, delta_major}) : error_sum;
    major_next = major_pos + 1'b1;
  end

endmodule

[dv/tb_bresenham_line_rasterizer.sv]
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer;
  import bresl_pkg::*;

  // Ceiling on the whole run.
  localparam int CYCLE_LIMIT   = 500000;
  // The block holds one registered result, so once the last pixel word is taken
  // there is nothing left in flight, loads included.
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_IDLE      = 18;
  localparam int DIR_ROWS      = 24;

  // One result word as the block presents it.
  typedef struct packed {
    logic                   pvalid;
    logic signed [9:0]      x;
    logic signed [9:0]      y;
    logic                   vis;
    logic [ADDR_W-1:0]      addr;
    logic [COLOUR_W-1:0]    colour;
    logic                   is_last;
  } pixel_word_t;

  // One row of the directed table. Where typed is set, want is the result word
  // read straight off the behaviour, and it is used instead of the predictor's.
  typedef struct packed {
    logic                   cmd;
    logic signed [9:0]      sx;
    logic signed [9:0]      sy;
    logic signed [9:0]      ex;
    logic signed [9:0]      ey;
    logic [COLOUR_W-1:0]    colour;
    logic                   typed;
    pixel_word_t            want;
  } stim_row_t;

  localparam pixel_word_t NO_PIXEL = '0;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = REG_FRAME_BASE;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    cmd = CMD_LOAD;
  logic signed [9:0]       start_x = '0;
  logic signed [9:0]       start_y = '0;
  logic signed [9:0]       end_x = '0;
  logic signed [9:0]       end_y = '0;
  logic [COLOUR_W-1:0]     colour = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    pixel_valid;
  logic signed [9:0]       pixel_x;
  logic signed [9:0]       pixel_y;
  logic                    visible;
  logic [ADDR_W-1:0]       pixel_address;
  logic [COLOUR_W-1:0]     pixel_colour;
  logic                    last;

  bresenham_line_rasterizer #(
    .COORD_BITS(10),
    .ROW_SHIFT (10)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .colour       (colour),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_valid  (pixel_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .visible      (visible),
    .pixel_address(pixel_address),
    .pixel_colour (pixel_colour),
    .last         (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the configuration registers.
  logic [ADDR_W-1:0]       base_reg = '0;
  logic [SIZE_W-1:0]       width_reg = RESET_SCREEN_WIDTH;
  logic [SIZE_W-1:0]       height_reg = RESET_SCREEN_HEIGHT;

  // Predictor copy of the line walk state. The major axis is the one along which
  // the walk advances by exactly one pixel per step.
  bit                      line_active = 1'b0;
  bit                      line_steep = 1'b0;
  bit                      minor_down = 1'b0;
  logic signed [10:0]      maj_pos = '0;
  logic signed [10:0]      maj_end = '0;
  logic signed [10:0]      min_pos = '0;
  logic signed [10:0]      d_major = '0;
  logic signed [10:0]      d_minor = '0;
  logic signed [11:0]      err_acc = '0;
  logic [COLOUR_W-1:0]     line_col = '0;

  pixel_word_t             pending_pixels[$];
  pixel_word_t             got_s;
  logic                    rdy_s = 1'b0;
  logic                    ovld_s = 1'b0;
  bit                      steady = 1'b0;
  int                      hold_cnt = 0;
  int                      cycle_cnt = 0;
  int                      fault_cnt = 0;
  int                      words_sent = 0;
  int                      pixels_checked = 0;
  int                      lines_loaded = 0;
  int                      settings_used = 0;
  stim_row_t               dir_rows [DIR_ROWS];

  function automatic int abs_diff(input int p, input int q);
    return (p > q) ? p - q : q - p;
  endfunction

  // Works out what one accepted word does to the line state, and the result
  // word it causes. A load causes none; a step always causes exactly one.
  task automatic rasterize_word(input logic c, input logic signed [9:0] sx,
                                input logic signed [9:0] sy, input logic signed [9:0] ex,
                                input logic signed [9:0] ey, input logic [COLOUR_W-1:0] col,
                                output bit yields, output pixel_word_t px);
    int a0, b0, a1, b1, t, xi, yi, e;
    bit at_end;
    px = NO_PIXEL;
    yields = 1'b0;
    if (c == CMD_LOAD) begin
      a0 = sx;
      b0 = sy;
      a1 = ex;
      b1 = ey;
      // A steep line walks along y, so the axes are swapped before ordering.
      line_steep = abs_diff(b1, b0) > abs_diff(a1, a0);
      if (line_steep) begin
        t = a0; a0 = b0; b0 = t;
        t = a1; a1 = b1; b1 = t;
      end
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      maj_pos = 11'(a0);
      maj_end = 11'(a1);
      min_pos = 11'(b0);
      minor_down = !(b0 < b1);
      d_major = 11'(a1 - a0);
      d_minor = 11'(abs_diff(b1, b0));
      err_acc = 12'(-((a1 - a0) / 2));
      line_col = col;
      line_active = 1'b1;
      lines_loaded++;
    end else begin
      yields = 1'b1;
      if (line_active) begin
        xi = line_steep ? min_pos : maj_pos;
        yi = line_steep ? maj_pos : min_pos;
        at_end = (maj_pos >= maj_end);
        px.pvalid = 1'b1;
        px.x = xi[9:0];
        px.y = yi[9:0];
        px.vis = (xi >= 0) && (xi < int'(width_reg)) && (yi >= 0) && (yi < int'(height_reg));
        // Coordinates count as signed, so a negative row or column wraps the
        // address below the frame base.
        px.addr = base_reg + 32'(yi << 10) + 32'(xi << 1);
        px.colour = line_col;
        px.is_last = at_end;
        // The minor coordinate moves when the error reaches zero, a tie included.
        e = err_acc + d_minor;
        if (e >= 0) begin
          min_pos = minor_down ? min_pos - 11'sd1 : min_pos + 11'sd1;
          e = e - d_major;
        end
        err_acc = 12'(e);
        if (at_end)
          line_active = 1'b0;
        else
          maj_pos = maj_pos + 11'sd1;
      end
    end
  endtask

  // Offers one word after a random gap and holds it until the block takes it.
  // When the gap is zero, valid stays high straight into the next word.
  task automatic send_word(input logic c, input logic signed [9:0] sx,
                           input logic signed [9:0] sy, input logic signed [9:0] ex,
                           input logic signed [9:0] ey, input logic [COLOUR_W-1:0] col,
                           input logic typed, input pixel_word_t want);
    int gap;
    bit yields;
    pixel_word_t px;
    gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    colour <= col;
    in_valid <= 1'b1;
    do @(posedge clk); while (rdy_s !== 1'b1);
    rasterize_word(c, sx, sy, ex, ey, col, yields, px);
    if (yields)
      pending_pixels.push_back(typed ? want : px);
    words_sent++;
  endtask

  // Stops offering words and waits until every predicted pixel has come back,
  // then lets the pipeline settle so that a trailing load has landed too.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive cycles. The upper bits of the
  // size writes carry junk, which the block must ignore.
  task automatic apply_config(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] w,
                              input logic [SIZE_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= {23'($urandom), w};
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= {23'($urandom), h};
    @(posedge clk);
    cfg_we <= 1'b0;
    base_reg = base;
    width_reg = w;
    height_reg = h;
    settings_used++;
  endtask

  // One setting of the registers followed by random traffic. Most of it is
  // whole lines: a load and then exactly as many steps as the line has pixels.
  // Some lines are cut short by the next load, some get extra steps that run
  // into an idle block, and a few words are plain noise.
  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] w,
                           input logic [SIZE_W-1:0] h, input int quota);
    int goal, n, pick, cx, cy;
    logic signed [9:0] x0, y0, x1, y1;
    drain_pixels();
    apply_config(base, w, h);
    goal = words_sent + quota;
    while (words_sent < goal) begin
      steady = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_word(1'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                  10'($urandom), 16'($urandom), 1'b0, NO_PIXEL);
      end else begin
        if ($urandom_range(0, 49) == 0) begin
          // A rare long line anywhere on the coordinate range.
          x0 = 10'($urandom);
          y0 = 10'($urandom);
          x1 = 10'($urandom);
          y1 = 10'($urandom);
        end else begin
          // Short lines around a random centre; the offsets still reach both
          // ends of the signed range.
          cx = int'($urandom_range(0, 975)) - 488;
          cy = int'($urandom_range(0, 975)) - 488;
          x0 = 10'(cx + int'($urandom_range(0, 48)) - 24);
          y0 = 10'(cy + int'($urandom_range(0, 48)) - 24);
          x1 = 10'(cx + int'($urandom_range(0, 48)) - 24);
          y1 = 10'(cy + int'($urandom_range(0, 48)) - 24);
        end
        n = abs_diff(x1, x0);
        if (abs_diff(y1, y0) > n)
          n = abs_diff(y1, y0);
        n = n + 1;
        pick = $urandom_range(0, 9);
        if (pick == 0)
          n = $urandom_range(0, n - 1);
        else if (pick == 1)
          n = n + $urandom_range(1, 3);
        // The phase keeps to its word quota; a line that would overrun it is
        // cut short.
        if (n > goal - words_sent - 1)
          n = goal - words_sent - 1;
        send_word(CMD_LOAD, x0, y0, x1, y1, 16'($urandom), 1'b0, NO_PIXEL);
        repeat (n)
          send_word(CMD_STEP, 10'($urandom), 10'($urandom), 10'($urandom),
                    10'($urandom), 16'($urandom), 1'b0, NO_PIXEL);
      end
    end
    steady = 1'b0;
  endtask

  function automatic void flag_field(input string name, input logic [31:0] want_v,
                                     input logic [31:0] got_v);
    if (got_v !== want_v) begin
      fault_cnt++;
      $display("%0t ns: %s expected %h got %h", $time, name, want_v, got_v);
    end
  endfunction

  // All block outputs are sampled on the falling edge, away from the active edge, so
  // the edge-side logic never races the block's own registers.
  always @(negedge clk) begin
    rdy_s = in_ready;
    ovld_s = out_valid;
    got_s = '{pixel_valid, pixel_x, pixel_y, visible, pixel_address, pixel_colour, last};
  end

  // Receiver: takes result words, stalling for a random gap after each,
  // and checks every one against the oldest prediction still waiting.
  always @(posedge clk) begin
    pixel_word_t want;
    int gap;
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
    end else if (ovld_s === 1'b1 && out_ready) begin
      if (pending_pixels.size() == 0) begin
        fault_cnt++;
        $display("%0t ns: result word with no prediction waiting, got %h", $time, got_s);
      end else begin
        want = pending_pixels.pop_front();
        flag_field("pixel_valid", 32'(want.pvalid), 32'(got_s.pvalid));
        flag_field("pixel_x", 32'(want.x), 32'(got_s.x));
        flag_field("pixel_y", 32'(want.y), 32'(got_s.y));
        flag_field("visible", 32'(want.vis), 32'(got_s.vis));
        flag_field("pixel_address", want.addr, got_s.addr);
        flag_field("pixel_colour", 32'(want.colour), 32'(got_s.colour));
        flag_field("last", 32'(want.is_last), 32'(got_s.is_last));
        pixels_checked++;
      end
      gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold_cnt <= gap - 1;
      end
    end else if (!out_ready) begin
      if (hold_cnt == 0)
        out_ready <= 1'b1;
      else
        hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("bresenham_line_rasterizer: mismatch");
      $finish;
    end
  end

  initial begin
    // Directed words at the reset setting: a frame base of zero on a 320 by 240
    // screen. A step on an idle block must come back all zero, a single-point
    // line is first and last at once, the full diagonal sits on both ends of the
    // coordinate range, a load abandons a steep line early, the screen edge
    // is crossed, and a short shallow line hits an error tie on its first step.
    dir_rows = '{
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b1, NO_PIXEL},
      '{CMD_LOAD, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'hFFFF, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b1,
        '{1'b1, 10'sd0, 10'sd0, 1'b1, 32'h0000_0000, 16'hFFFF, 1'b1}},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b1, NO_PIXEL},
      '{CMD_LOAD, -10'sd512, -10'sd512, 10'sd511, 10'sd511, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b1,
        '{1'b1, -10'sd512, -10'sd512, 1'b0, 32'hFFF7_FC00, 16'h0000, 1'b0}},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_LOAD, 10'sd5, -10'sd3, 10'sd2, 10'sd10, 16'h1234, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_LOAD, 10'sd511, 10'sd0, -10'sd512, 10'sd1, 16'hA5A5, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_LOAD, 10'sd319, 10'sd239, 10'sd320, 10'sd240, 16'h5A5A, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b1,
        '{1'b1, 10'sd320, 10'sd240, 1'b0, 32'd246400, 16'h5A5A, 1'b1}},
      '{CMD_LOAD, 10'sd0, 10'sd0, 10'sd4, 10'sd2, 16'h0F0F, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b0, NO_PIXEL},
      '{CMD_STEP, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'h0000, 1'b1, NO_PIXEL}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                dir_rows[i].ey, dir_rows[i].colour, dir_rows[i].typed, dir_rows[i].want);

    // Each phase drains the block before its register writes. The settings
    // include the largest and smallest screens, a zero-sized screen on which
    // nothing is visible, and frame bases that make the address wrap.
    run_phase($urandom, 9'd320, 9'd240, 180);
    run_phase(32'hFFFF_FFFF, 9'd511, 9'd511, 180);
    run_phase(32'h0000_0000, 9'd1, 9'd1, 180);
    run_phase($urandom, 9'd0, 9'd0, 180);
    run_phase($urandom, 9'($urandom_range(1, 511)), 9'($urandom_range(1, 511)), 180);
    run_phase(32'h8000_0000, 9'd511, 9'd1, 180);
    run_phase($urandom, 9'($urandom_range(1, 511)), 9'($urandom_range(1, 511)), 180);
    run_phase(32'hFFFF_F000, 9'd64, 9'd480, 180);
    drain_pixels();

    $display("Sent %0d words (%0d line loads) under %0d register settings;",
             words_sent, lines_loaded, settings_used);
    $display("checked %0d pixel words field by field, %0d faults.", pixels_checked, fault_cnt);
    if (fault_cnt == 0)
      $display("bresenham_line_rasterizer: match");
    else
      $display("bresenham_line_rasterizer: mismatch");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bresl_pkg.sv
rtl/core/bresl_setup.sv
rtl/core/bresl_step.sv
rtl/core/bresenham_line_rasterizer.sv
dv/tb_bresenham_line_rasterizer.sv
